FILE: design/lzwe_pkg.sv
// Shared constants, types and helper functions of the LZW encoder.
// No dependencies; the divider, packer and encoder top refer to it by scoped names.
package lzwe_pkg;

  localparam int MAX_CODE_BITS   = 12;
  localparam int START_CODE_BITS = 9;
  localparam int TABLE_ENTRIES   = 5021;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int PRB_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int EPOCH_W = 4;
  localparam int CW_W    = 4;
  localparam int DVD_W   = 39;
  localparam int HASH_FOLDS = (2 ** MAX_CODE_BITS + TABLE_ENTRIES - 1) / TABLE_ENTRIES;

  localparam logic [MAX_CODE_BITS-1:0] CODE_CLEAR = MAX_CODE_BITS'(256);
  localparam logic [MAX_CODE_BITS-1:0] CODE_END   = MAX_CODE_BITS'(257);
  localparam logic [MAX_CODE_BITS:0]   CODE_FIRST = (MAX_CODE_BITS + 1)'(258);
  localparam logic [15:0]              RATIO_START = 16'd100;
  localparam logic [15:0]              CHECK_RESET = 16'd100;
  localparam logic [31:0]              CHECKPOINT_RESET = 32'd100;

  typedef struct packed {
    logic [EPOCH_W-1:0]       epoch;
    logic [MAX_CODE_BITS-1:0] code;
    logic [MAX_CODE_BITS-1:0] prefix;
    logic [7:0]               chr;
  } entry_t;

  localparam int WORD_W = $bits(entry_t);

  typedef enum logic {
    PACK_EMIT,
    PACK_FINISH
  } pack_op_e;

  typedef struct packed {
    logic                     valid;
    pack_op_e                 op;
    logic [MAX_CODE_BITS-1:0] code;
    logic [CW_W-1:0]          width;
    logic                     last;
  } pack_cmd_t;

  typedef struct packed {
    logic busy;
    logic byte_pulse;
  } pack_sts_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Fold (char, prefix) into a home slot with HASH_FOLDS compare-subtract steps.
  function automatic logic [IDX_W-1:0] hash_index(logic [MAX_CODE_BITS-1:0] prefix,
                                                  logic [7:0] ch);
    logic [MAX_CODE_BITS-1:0] v;
    v = {ch, {(MAX_CODE_BITS - 8){1'b0}}} ^ prefix;
    for (int i = 0; i < HASH_FOLDS; i++) begin
      if (32'(v) >= TABLE_ENTRIES) begin
        v = v - MAX_CODE_BITS'(TABLE_ENTRIES);
      end
    end
    return IDX_W'(v);
  endfunction

endpackage

FILE: design/lzwe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lzwe_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: design/lzwe_div.sv
// Restoring divider, one quotient bit per cycle, for the ratio check.
// Depends on lzwe_pkg.
module lzwe_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lzwe_pkg::DVD_W-1:0] dividend_i,
  input  logic [31:0]              divisor_i,
  output logic                     done_o,
  output logic [lzwe_pkg::DVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(lzwe_pkg::DVD_W + 1);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [32:0]                rem_q, rem_d;
  logic [lzwe_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [31:0]                dsr_q, dsr_d;
  logic [32:0]                rem_sh;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[31:0], quo_q[lzwe_pkg::DVD_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[lzwe_pkg::DVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d    = rem_sh - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(lzwe_pkg::DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: design/lzwe_pack.sv
// Bit packer: merges codes MSB first, drains bytes, marks the last beat.
// Depends on lzwe_pkg.
module lzwe_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lzwe_pkg::pack_cmd_t   cmd_i,
  output lzwe_pkg::pack_sts_t   sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o,
  output logic                  stream_done_o
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_DRAIN,
    P_PAD,
    P_FIN
  } pstate_e;

  pstate_e     st_q, st_d;
  logic [31:0] buf_q, buf_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        pend_v_q, pend_v_d;
  logic [7:0]  pend_q, pend_d;
  logic        fin_last_q, fin_last_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        orl_q, orl_d;
  logic        osd_q, osd_d;
  logic        pulse;
  logic        out_free;
  logic        prod_ok;
  logic [31:0] code_w;
  logic [31:0] mask_w;
  logic [5:0]  shamt;

  assign out_free = !ov_q || out_ready_i;
  assign prod_ok  = !pend_v_q || out_free;
  assign mask_w   = (32'd1 << cmd_i.width) - 32'd1;
  assign code_w   = 32'(cmd_i.code) & mask_w;
  assign shamt    = 6'd32 - 6'(cmd_i.width) - cnt_q;

  always_comb begin
    st_d       = st_q;
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    fin_last_d = fin_last_q;
    ov_d       = ov_q && !out_ready_i;
    ob_d       = ob_q;
    orl_d      = orl_q;
    osd_d      = osd_q;
    pulse      = 1'b0;
    case (st_q)
      P_IDLE: begin
        if (cmd_i.valid) begin
          case (cmd_i.op)
            lzwe_pkg::PACK_EMIT: begin
              buf_d = buf_q | (code_w << shamt);
              cnt_d = cnt_q + 6'(cmd_i.width);
              st_d  = P_DRAIN;
            end
            default: begin
              fin_last_d = cmd_i.last;
              st_d       = cmd_i.last ? P_PAD : P_FIN;
            end
          endcase
        end
      end
      P_DRAIN: begin
        if (cnt_q < 6'd8) begin
          st_d = P_IDLE;
        end else if (prod_ok) begin
          // Release the held beat, hold the new one until the next byte or a finish.
          if (pend_v_q) begin
            ov_d  = 1'b1;
            ob_d  = pend_q;
            orl_d = 1'b0;
            osd_d = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = buf_q[31:24];
          buf_d    = buf_q << 8;
          cnt_d    = cnt_q - 6'd8;
          pulse    = 1'b1;
        end
      end
      P_PAD: begin
        if (cnt_q == 6'd0) begin
          buf_d = '0;
          st_d  = P_FIN;
        end else if (prod_ok) begin
          if (pend_v_q) begin
            ov_d  = 1'b1;
            ob_d  = pend_q;
            orl_d = 1'b0;
            osd_d = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = buf_q[31:24];
          buf_d    = '0;
          cnt_d    = '0;
          pulse    = 1'b1;
          st_d     = P_FIN;
        end
      end
      P_FIN: begin
        if (!pend_v_q) begin
          st_d = P_IDLE;
        end else if (out_free) begin
          ov_d     = 1'b1;
          ob_d     = pend_q;
          orl_d    = 1'b1;
          osd_d    = fin_last_q;
          pend_v_d = 1'b0;
          st_d     = P_IDLE;
        end
      end
      default: st_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= P_IDLE;
      buf_q      <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      fin_last_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      pend_v_q   <= pend_v_d;
      fin_last_q <= fin_last_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    ob_q   <= ob_d;
    orl_q  <= orl_d;
    osd_q  <= osd_d;
  end

  assign sts_o.busy       = (st_q != P_IDLE);
  assign sts_o.byte_pulse = pulse;
  assign out_valid_o      = ov_q;
  assign out_byte_o       = ob_q;
  assign run_last_o       = orl_q;
  assign stream_done_o    = osd_q;

endmodule

FILE: design/lzw_variable_width_encoder_top.sv
// LZW encoder top: probe sequencer over the dictionary RAM, packer, ratio divider.
// Each hash probe reads the RAM (S_RD), then compares (S_CMP); a hit extends the string,
// a miss emits one code through the packer, which waits while the output is not ready.
// A ratio check runs the divider, one quotient bit per cycle.
// Reset: async, active low; afterwards a clearing pass writes all TABLE_ENTRIES (5021)
// dictionary words, one per cycle, before the first input beat; it repeats on epoch wrap.
module lzw_variable_width_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        stream_done_o
);

  localparam int MCB   = lzwe_pkg::MAX_CODE_BITS;
  localparam int IDX_W = lzwe_pkg::IDX_W;
  localparam int PRB_W = lzwe_pkg::PRB_W;
  localparam int EW    = lzwe_pkg::EPOCH_W;
  localparam int CW_W  = lzwe_pkg::CW_W;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_INS,
    S_GROW,
    S_DIV,
    S_CLR,
    S_CLRW,
    S_FIN,
    S_L1,
    S_L2,
    S_L3,
    S_L4,
    S_L5
  } state_e;

  state_e                 state_q, state_d;
  logic [MCB-1:0]         cur_q, cur_d;
  logic [7:0]             byte_q, byte_d;
  logic                   last_q, last_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       off_q, off_d;
  logic [PRB_W-1:0]       n_q, n_d;
  logic                   free_q, free_d;
  logic [MCB:0]           nfc_q, nfc_d;
  logic [CW_W-1:0]        cw_q, cw_d;
  logic [MCB-1:0]         wlc_q, wlc_d;
  logic [31:0]            in_cnt_q, in_cnt_d;
  logic [31:0]            out_cnt_q, out_cnt_d;
  logic [15:0]            prev_q, prev_d;
  logic [31:0]            ncp_q, ncp_d;
  logic                   started_q, started_d;
  logic [EW-1:0]          epoch_q, epoch_d;
  logic [IDX_W-1:0]       sweep_q, sweep_d;
  logic                   need_sweep_q, need_sweep_d;
  logic [15:0]            interval_q;

  // RAM port signals
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  lzwe_pkg::entry_t       ram_wdata;
  logic                   ram_re;
  lzwe_pkg::entry_t       ram_rdata;

  lzwe_pkg::pack_cmd_t    pcmd;
  lzwe_pkg::pack_sts_t    psts;

  logic                   div_start;
  logic                   div_done;
  logic [lzwe_pkg::DVD_W-1:0] div_quot;
  logic [lzwe_pkg::DVD_W-1:0] dividend;
  logic [15:0]            ratio;

  logic [IDX_W-1:0]       home;
  logic [IDX_W:0]         wrap_sum;
  logic [IDX_W-1:0]       idx_next;
  logic [MCB-1:0]         wlc_grow;
  logic                   accept;

  // Configuration: check_interval only, to be written while idle; the block does not enforce that.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= lzwe_pkg::CHECK_RESET;
    end else if (cfg_valid_i) begin
      interval_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !psts.busy;
  assign accept     = in_valid_i && in_ready_o;

  assign home     = lzwe_pkg::hash_index(cur_q, data_byte_i);
  assign wrap_sum = (IDX_W + 1)'(idx_q) + (IDX_W + 1)'(lzwe_pkg::TABLE_ENTRIES)
                    - (IDX_W + 1)'(off_q);
  assign idx_next = (idx_q >= off_q) ? (idx_q - off_q) : wrap_sum[IDX_W-1:0];
  assign wlc_grow = MCB'(((MCB + 1)'(1) << (cw_q + 1'b1)) - 1'b1);

  // out_count * 100 by shift-and-add.
  assign dividend = ({7'd0, out_cnt_q} << 6) + ({7'd0, out_cnt_q} << 5)
                    + ({7'd0, out_cnt_q} << 2);
  assign ratio    = (|div_quot[lzwe_pkg::DVD_W-1:16]) ? 16'hFFFF : div_quot[15:0];

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    byte_d       = byte_q;
    last_d       = last_q;
    idx_d        = idx_q;
    off_d        = off_q;
    n_d          = n_q;
    free_d       = free_q;
    nfc_d        = nfc_q;
    cw_d         = cw_q;
    wlc_d        = wlc_q;
    in_cnt_d     = in_cnt_q;
    out_cnt_d    = psts.byte_pulse ? lzwe_pkg::sat_add32(out_cnt_q, 32'd1) : out_cnt_q;
    prev_d       = prev_q;
    ncp_d        = ncp_q;
    started_d    = started_q;
    epoch_d      = epoch_q;
    sweep_d      = sweep_q;
    need_sweep_d = need_sweep_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    pcmd         = '0;
    pcmd.op      = lzwe_pkg::PACK_EMIT;
    pcmd.width   = cw_q;
    div_start    = 1'b0;

    case (state_q)
      // Write an old epoch over every slot, one per cycle.
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == IDX_W'(lzwe_pkg::TABLE_ENTRIES - 1)) begin
          sweep_d      = '0;
          need_sweep_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          byte_d = data_byte_i;
          last_d = last_byte_i;
          if (!started_q) begin
            // New stream: restart table, counters and width.
            if (epoch_q == {EW{1'b1}}) begin
              epoch_d      = EW'(1);
              need_sweep_d = 1'b1;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
            cw_d      = CW_W'(lzwe_pkg::START_CODE_BITS);
            wlc_d     = MCB'((1 << lzwe_pkg::START_CODE_BITS) - 1);
            nfc_d     = lzwe_pkg::CODE_FIRST;
            in_cnt_d  = 32'd1;
            out_cnt_d = '0;
            prev_d    = lzwe_pkg::RATIO_START;
            started_d = 1'b1;
            cur_d     = MCB'(data_byte_i);
            state_d   = S_START;
          end else begin
            in_cnt_d = lzwe_pkg::sat_add32(in_cnt_q, 32'd1);
            idx_d    = home;
            off_d    = (home == '0) ? IDX_W'(1) : IDX_W'(lzwe_pkg::TABLE_ENTRIES) - home;
            n_d      = '0;
            state_d  = S_RD;
          end
        end
      end
      S_START: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.code  = lzwe_pkg::CODE_CLEAR;
          state_d    = S_FIN;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (ram_rdata.epoch != epoch_q) begin
          free_d  = 1'b1;
          state_d = S_INS;
        end else if (ram_rdata.prefix == cur_q && ram_rdata.chr == byte_q) begin
          cur_d   = ram_rdata.code;
          state_d = S_FIN;
        end else begin
          // Advance by the secondary step; give up after a full lap.
          idx_d = idx_next;
          n_d   = n_q + 1'b1;
          if (n_q == PRB_W'(lzwe_pkg::TABLE_ENTRIES - 1)) begin
            free_d  = 1'b0;
            state_d = S_INS;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_INS: begin
        if (!psts.busy) begin
          if (free_q && (nfc_q <= {1'b0, wlc_q})) begin
            ram_we           = 1'b1;
            ram_wdata.epoch  = epoch_q;
            ram_wdata.code   = nfc_q[MCB-1:0];
            ram_wdata.prefix = cur_q;
            ram_wdata.chr    = byte_q;
            nfc_d            = nfc_q + 1'b1;
          end
          pcmd.valid = 1'b1;
          pcmd.code  = cur_q;
          cur_d      = MCB'(byte_q);
          state_d    = S_GROW;
        end
      end
      S_GROW: begin
        if (nfc_q > {1'b0, wlc_q}) begin
          if (cw_q < CW_W'(MCB)) begin
            cw_d    = cw_q + 1'b1;
            wlc_d   = wlc_grow;
            state_d = S_FIN;
          end else if (in_cnt_q > ncp_q) begin
            // Wait until every beat of this code is counted.
            if (!psts.busy) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ratio > prev_q) begin
            state_d = S_CLR;
          end else begin
            prev_d  = ratio;
            ncp_d   = lzwe_pkg::sat_add32(in_cnt_q, {16'd0, interval_q});
            state_d = S_FIN;
          end
        end
      end
      S_CLR: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.code  = lzwe_pkg::CODE_CLEAR;
          state_d    = S_CLRW;
        end
      end
      S_CLRW: begin
        // Drop the table once the clear code's beats are counted.
        if (!psts.busy) begin
          if (epoch_q == {EW{1'b1}}) begin
            epoch_d      = EW'(1);
            need_sweep_d = 1'b1;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
          cw_d      = CW_W'(lzwe_pkg::START_CODE_BITS);
          wlc_d     = MCB'((1 << lzwe_pkg::START_CODE_BITS) - 1);
          nfc_d     = lzwe_pkg::CODE_FIRST;
          in_cnt_d  = '0;
          out_cnt_d = '0;
          prev_d    = lzwe_pkg::RATIO_START;
          ncp_d     = {16'd0, interval_q};
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (last_q) begin
          state_d = S_L1;
        end else if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.op    = lzwe_pkg::PACK_FINISH;
          pcmd.last  = 1'b0;
          state_d    = need_sweep_q ? S_SWEEP : S_IDLE;
        end
      end
      S_L1: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.code  = cur_q;
          state_d    = S_L2;
        end
      end
      S_L2: begin
        if ((nfc_q == {1'b0, wlc_q}) && (cw_q < CW_W'(MCB))) begin
          cw_d  = cw_q + 1'b1;
          wlc_d = wlc_grow;
        end
        state_d = S_L3;
      end
      S_L3: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.code  = lzwe_pkg::CODE_END;
          state_d    = S_L4;
        end
      end
      S_L4: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.code  = lzwe_pkg::CODE_END;
          state_d    = S_L5;
        end
      end
      S_L5: begin
        if (!psts.busy) begin
          pcmd.valid = 1'b1;
          pcmd.op    = lzwe_pkg::PACK_FINISH;
          pcmd.last  = 1'b1;
          started_d  = 1'b0;
          state_d    = need_sweep_q ? S_SWEEP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      cur_q        <= '0;
      nfc_q        <= lzwe_pkg::CODE_FIRST;
      cw_q         <= CW_W'(lzwe_pkg::START_CODE_BITS);
      wlc_q        <= MCB'((1 << lzwe_pkg::START_CODE_BITS) - 1);
      in_cnt_q     <= '0;
      out_cnt_q    <= '0;
      prev_q       <= lzwe_pkg::RATIO_START;
      ncp_q        <= lzwe_pkg::CHECKPOINT_RESET;
      started_q    <= 1'b0;
      epoch_q      <= EW'(1);
      sweep_q      <= '0;
      need_sweep_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      nfc_q        <= nfc_d;
      cw_q         <= cw_d;
      wlc_q        <= wlc_d;
      in_cnt_q     <= in_cnt_d;
      out_cnt_q    <= out_cnt_d;
      prev_q       <= prev_d;
      ncp_q        <= ncp_d;
      started_q    <= started_d;
      epoch_q      <= epoch_d;
      sweep_q      <= sweep_d;
      need_sweep_q <= need_sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    off_q  <= off_d;
    n_q    <= n_d;
    free_q <= free_d;
  end

  lzwe_ram #(
    .DEPTH (lzwe_pkg::TABLE_ENTRIES),
    .WIDTH (lzwe_pkg::WORD_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  lzwe_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (pcmd),
    .sts_o         (psts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

  lzwe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (in_cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

`ifndef SYNTHESIS
  // No input beat is taken during a clearing pass.
  a_sweep_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> !in_ready_o)
    else $error("input accepted during table clear");

  // Code width stays between start and maximum width.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw_q >= CW_W'(lzwe_pkg::START_CODE_BITS)) && (cw_q <= CW_W'(MCB)))
    else $error("code width out of range");

  // Free code never runs more than one past the width limit.
  a_free_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfc_q <= ({1'b0, wlc_q} + 1'b1))
    else $error("next free code beyond limit");

  // Divider is only started with a nonzero input count.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (in_cnt_q != '0))
    else $error("ratio check with zero input count");
`endif

endmodule

FILE: tb/sv/lzw_variable_width_encoder_top_tb.sv
// Self-checking testbench for lzw_variable_width_encoder_top: predicts packed code bytes.
// Depends on lzwe_pkg and the encoder top; drives valid/ready channels with random gaps.
`timescale 1ns / 100ps

module lzw_variable_width_encoder_top_tb;

  localparam int TBL = lzwe_pkg::TABLE_ENTRIES;
  localparam int WMAX = lzwe_pkg::MAX_CODE_BITS;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       rl;
    logic       sd;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        stream_done_o;

  lzw_variable_width_encoder_top DUT (.*);

  // Predictor state: dictionary and stream bookkeeping.
  bit          d_used [TBL];
  int unsigned d_code [TBL];
  int unsigned d_pref [TBL];
  int unsigned d_char [TBL];
  int unsigned cur_str, free_code, cwidth, wlimit, pbuf, pcnt;
  int unsigned n_in, n_out, prev_ratio, checkpoint, interval;
  bit          started;

  in_beat_t  pending_bytes[$];
  out_beat_t expected_bytes[$];
  out_beat_t step_bytes[$];
  int        err_count = 0;
  int        in_gap = 0, out_gap = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned sat32(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(s);
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic put_byte(input int unsigned b);
    out_beat_t o;
    o.ob = b[7:0];
    o.rl = 1'b0;
    o.sd = 1'b0;
    step_bytes.push_back(o);
    n_out = sat32(n_out, 1);
  endtask

  task automatic pack_code(input int unsigned code);
    int unsigned w;
    w = cwidth;
    code &= (1 << w) - 1;
    pbuf |= code << (32 - w - pcnt);
    pcnt += w;
    while (pcnt >= 8) begin
      put_byte(pbuf >> 24);
      pbuf <<= 8;
      pcnt -= 8;
    end
  endtask

  task automatic restart_dictionary();
    foreach (d_used[i]) d_used[i] = 1'b0;
    cwidth = lzwe_pkg::START_CODE_BITS;
    wlimit = (1 << lzwe_pkg::START_CODE_BITS) - 1;
    free_code = lzwe_pkg::CODE_FIRST;
  endtask

  // Probe the dictionary: 1 hit, 0 free slot, -1 table exhausted.
  function automatic int probe(input int unsigned pref, input int unsigned ch,
                               output int unsigned slot);
    int unsigned idx, off;
    idx = ((ch << (WMAX - 8)) ^ pref) % TBL;
    off = (idx == 0) ? 1 : (TBL - idx);
    slot = 0;
    for (int n = 0; n < TBL; n++) begin
      if (!d_used[idx]) begin
        slot = idx;
        return 0;
      end
      if (d_pref[idx] == pref && d_char[idx] == ch) begin
        slot = idx;
        return 1;
      end
      idx = (idx >= off) ? idx - off : idx + TBL - off;
    end
    return -1;
  endfunction

  task automatic encode_byte(input in_beat_t it);
    int unsigned slot, ratio;
    longint unsigned q;
    int r;
    step_bytes.delete();
    if (!started) begin
      restart_dictionary();
      pbuf = 0; pcnt = 0; n_in = 0; n_out = 0;
      prev_ratio = lzwe_pkg::RATIO_START;
      started = 1'b1;
      pack_code(lzwe_pkg::CODE_CLEAR);
      n_in = 1;
      cur_str = it.data;
    end else begin
      n_in = sat32(n_in, 1);
      r = probe(cur_str, it.data, slot);
      if (r == 1) begin
        cur_str = d_code[slot];
      end else begin
        if (r == 0 && free_code <= wlimit) begin
          d_used[slot] = 1'b1;
          d_code[slot] = free_code;
          d_pref[slot] = cur_str;
          d_char[slot] = it.data;
          free_code++;
        end
        pack_code(cur_str);
        cur_str = it.data;
        if (free_code > wlimit) begin
          if (cwidth < WMAX) begin
            cwidth++;
            wlimit = (1 << cwidth) - 1;
          end else if (n_in > checkpoint) begin
            q = (longint'(n_out) * 100) / n_in;
            ratio = (q > 64'hFFFF) ? 32'hFFFF : int'(q);
            if (ratio > prev_ratio) begin
              pack_code(lzwe_pkg::CODE_CLEAR);
              restart_dictionary();
              n_in = 0; n_out = 0;
              prev_ratio = lzwe_pkg::RATIO_START;
            end else begin
              prev_ratio = ratio;
            end
            checkpoint = sat32(n_in, interval);
          end
        end
      end
    end
    if (it.last) begin
      pack_code(cur_str);
      if (free_code == wlimit && cwidth < WMAX) begin
        cwidth++;
        wlimit = (1 << cwidth) - 1;
      end
      pack_code(lzwe_pkg::CODE_END);
      pack_code(lzwe_pkg::CODE_END);
      if (pcnt > 0) put_byte(pbuf >> 24);
      pbuf = 0; pcnt = 0;
      started = 1'b0;
      if (step_bytes.size() > 0) step_bytes[$].sd = 1'b1;
    end
    if (step_bytes.size() > 0) step_bytes[$].rl = 1'b1;
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endtask

  // Input driver: present queued beats with random gaps between them.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      encode_byte('{data: data_byte_i, last: last_byte_i});
      in_gap = draw_gap();
    end
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0 || pending_bytes.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_beat_t b;
        b = pending_bytes.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= b.data;
        last_byte_i <= b.last;
      end
    end
  end

  // Output monitor: compare each accepted beat, then stall ready at random.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected beat", out_byte_o, 0);
      end else begin
        out_beat_t e;
        e = expected_bytes.pop_front();
        if (out_byte_o !== e.ob) report_mismatch("out_byte", out_byte_o, e.ob);
        if (run_last_o !== e.rl) report_mismatch("run_last", run_last_o, e.rl);
        if (stream_done_o !== e.sd) report_mismatch("stream_done", stream_done_o, e.sd);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap = draw_gap();
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_interval(input int unsigned v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    interval = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_byte(input int unsigned d, input bit l);
    pending_bytes.push_back('{data: d[7:0], last: l});
  endtask

  // Mostly well-formed streams: repetitive text-like content so strings grow.
  task automatic queue_stream(input int len, input int alphabet);
    int unsigned base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++)
      queue_byte((alphabet == 0) ? $urandom_range(0, 255)
                 : (base + $urandom_range(0, alphabet - 1)) & 8'hFF, i == len - 1);
  endtask

  initial begin
    interval = 100;
    checkpoint = 100;
    started = 1'b0;
    restart_dictionary();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-byte streams at the extremes, repeats, full range.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hAA, 1'b0); queue_byte(8'hAA, 1'b0); queue_byte(8'hAA, 1'b0);
    queue_byte(8'hAA, 1'b0); queue_byte(8'h55, 1'b1);
    for (int i = 0; i < 12; i++) queue_byte(i * 23, i == 11);
    wait_drained();

    // Small interval for ratio checks, though these streams are too short to fill the table.
    write_interval(1);
    queue_stream(60, 4);
    queue_stream(40, 0);
    wait_drained();
    write_interval(16'hFFFF);
    queue_stream(30, 2);
    queue_stream(10, 256);
    wait_drained();
    write_interval($urandom_range(2, 400));
    queue_stream(25, 16);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: lzw_variable_width_encoder_top.f
design/lzwe_pkg.sv
design/lzwe_ram.sv
design/lzwe_div.sv
design/lzwe_pack.sv
design/lzw_variable_width_encoder_top.sv
tb/sv/lzw_variable_width_encoder_top_tb.sv
